>>> hdl/mcconv_pkg.sv
`timescale 1ns / 1ps

package mcconv_pkg;

    // Request codes carried in s_tuser
    localparam logic [1:0] REQ_LOAD_WEIGHT = 2'd0;
    localparam logic [1:0] REQ_LOAD_IMAGE  = 2'd1;
    localparam logic [1:0] REQ_COMPUTE     = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] REG_HEIGHT       = 3'd0;
    localparam logic [2:0] REG_WIDTH        = 3'd1;
    localparam logic [2:0] REG_IN_CHANNELS  = 3'd2;
    localparam logic [2:0] REG_OUT_CHANNELS = 3'd3;
    localparam logic [2:0] REG_KERNEL_SIZE  = 3'd4;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 6;
    localparam int DIM_W      = 6;
    localparam int CH_W       = 4;
    localparam int KER_W      = 3;
    localparam int POS_W      = 8;
    localparam int S_TDATA_W  = 40;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 32;
    localparam int M_TUSER_W  = 4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP_A,
        ST_SETUP_B,
        ST_SETUP_C,
        ST_RUN,
        ST_DRAIN,
        ST_EMIT
    } seq_state_t;

endpackage

>>> hdl/mcconv_ram.sv
`timescale 1ns / 1ps

module mcconv_ram #(
    parameter int DATA_W = 16,
    parameter int DEPTH  = 1024
) (
    input  logic                                     aclk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [DATA_W-1:0]                        wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [DATA_W-1:0]                        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hdl/multichannel_conv2d_same_pad_unit.sv
`timescale 1ns / 1ps
// Load transfers leave the block in its idle state, so it stays ready for more input.
// A compute transfer inside the image runs each output channel in turn, doing one
// multiply-accumulate per cycle through a single shared MAC fed by the image and
// filter RAM read ports, plus pipeline drain.
// aresetn (synchronous, active low) restores the register defaults and clears
// control state; RAM contents are undefined until loaded.

module multichannel_conv2d_same_pad_unit #(
    parameter int MAX_ROWS   = 32,
    parameter int MAX_COLS   = 32,
    parameter int MAX_IN_CH  = 8,
    parameter int MAX_OUT_CH = 8,
    parameter int MAX_KERNEL = 5
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // load_index[12:0], load_value[28:13], pixel_row[33:29], pixel_col[38:34]
    input  logic [mcconv_pkg::S_TDATA_W-1:0] s_tdata,
    // req_type[1:0]
    input  logic [mcconv_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // out_value[31:0]
    output logic [mcconv_pkg::M_TDATA_W-1:0] m_tdata,
    // out_channel[2:0], saturated[3]
    output logic [mcconv_pkg::M_TUSER_W-1:0] m_tuser,
    output logic                             m_tlast,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [mcconv_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mcconv_pkg::CFG_DATA_W-1:0] cfg_data
);

    import mcconv_pkg::*;

    localparam int IMG_DEPTH = MAX_ROWS * MAX_COLS * MAX_IN_CH;
    localparam int FLT_DEPTH = MAX_OUT_CH * MAX_KERNEL * MAX_KERNEL * MAX_IN_CH;
    localparam int IMG_AW    = (IMG_DEPTH > 1) ? $clog2(IMG_DEPTH) : 1;
    localparam int FLT_AW    = (FLT_DEPTH > 1) ? $clog2(FLT_DEPTH) : 1;
    localparam int IA_W      = IMG_AW + 4;
    localparam int ACC_W     = 33 + $clog2(MAX_IN_CH * MAX_KERNEL * MAX_KERNEL + 1);
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(64'sh7FFFFFFF);
    localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

    // configuration registers
    logic [DIM_W-1:0] height_reg, width_reg;
    logic [CH_W-1:0]  in_ch_reg, out_ch_reg;
    logic [KER_W-1:0] kernel_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            height_reg <= DIM_W'(32);
            width_reg  <= DIM_W'(32);
            in_ch_reg  <= CH_W'(8);
            out_ch_reg <= CH_W'(8);
            kernel_reg <= KER_W'(3);
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_HEIGHT:       height_reg <= cfg_data;
                REG_WIDTH:        width_reg  <= cfg_data;
                REG_IN_CHANNELS:  in_ch_reg  <= cfg_data[CH_W-1:0];
                REG_OUT_CHANNELS: out_ch_reg <= cfg_data[CH_W-1:0];
                REG_KERNEL_SIZE:  kernel_reg <= cfg_data[KER_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    // registers in use, clamped to 1..maximum
    logic [DIM_W-1:0] h_eff, w_eff;
    logic [CH_W-1:0]  ci_eff, co_eff;
    logic [KER_W-1:0] k_eff, pad;

    always_comb begin
        h_eff  = (height_reg == '0) ? DIM_W'(1) :
                 (32'(height_reg) > MAX_ROWS) ? DIM_W'(MAX_ROWS) : height_reg;
        w_eff  = (width_reg == '0) ? DIM_W'(1) :
                 (32'(width_reg) > MAX_COLS) ? DIM_W'(MAX_COLS) : width_reg;
        ci_eff = (in_ch_reg == '0) ? CH_W'(1) :
                 (32'(in_ch_reg) > MAX_IN_CH) ? CH_W'(MAX_IN_CH) : in_ch_reg;
        co_eff = (out_ch_reg == '0) ? CH_W'(1) :
                 (32'(out_ch_reg) > MAX_OUT_CH) ? CH_W'(MAX_OUT_CH) : out_ch_reg;
        k_eff  = (kernel_reg == '0) ? KER_W'(1) :
                 (32'(kernel_reg) > MAX_KERNEL) ? KER_W'(MAX_KERNEL) : kernel_reg;
        pad    = k_eff >> 1;
    end

    // input fields
    logic [1:0]  req_type;
    logic [12:0] load_index;
    logic [15:0] load_value;
    logic [4:0]  pixel_row, pixel_col;

    assign req_type   = s_tuser[1:0];
    assign load_index = s_tdata[12:0];
    assign load_value = s_tdata[28:13];
    assign pixel_row  = s_tdata[33:29];
    assign pixel_col  = s_tdata[38:34];

    logic s_xfer;
    assign s_xfer = s_tvalid && s_tready;

    logic img_we, flt_we;
    assign img_we = s_xfer && (req_type == REQ_LOAD_IMAGE) && (32'(load_index) < IMG_DEPTH);
    assign flt_we = s_xfer && (req_type == REQ_LOAD_WEIGHT) && (32'(load_index) < FLT_DEPTH);

    logic start_px;
    assign start_px = s_xfer && (req_type == REQ_COMPUTE) &&
                      ({1'b0, pixel_row} < h_eff) && ({1'b0, pixel_col} < w_eff);

    // sequencer state
    seq_state_t state_reg, state_next;

    logic signed [POS_W-1:0] rstart_reg, rstart_next, cstart_reg, cstart_next;
    logic signed [POS_W-1:0] ih_reg, ih_next, iw_reg, iw_next;
    logic signed [IA_W-1:0]  wci_reg, wci_next, rowpart_reg, rowpart_next;
    logic signed [IA_W-1:0]  colpart_reg, colpart_next, base_reg, base_next;
    logic signed [IA_W-1:0]  img_addr_reg, img_addr_next, row_addr_reg, row_addr_next;
    logic [FLT_AW-1:0]       flt_addr_reg, flt_addr_next;
    logic [CH_W-1:0]         co_reg, co_next, ci_reg, ci_next;
    logic [KER_W-1:0]        kh_reg, kh_next, kw_reg, kw_next;
    logic [1:0]              drain_reg, drain_next;
    logic                    acc_clr;
    logic                    issue, in_image;

    // output register
    logic                 m_valid_reg, m_valid_next;
    logic [31:0]          m_value_reg, m_value_next;
    logic [2:0]           m_chan_reg, m_chan_next;
    logic                 m_sat_reg, m_sat_next;
    logic                 m_last_reg, m_last_next;

    logic signed [ACC_W-1:0] acc_reg;
    logic                    out_free;

    assign out_free = !m_valid_reg || m_tready;

    assign in_image = (ih_reg >= 0) && (ih_reg < $signed({2'b0, h_eff})) &&
                      (iw_reg >= 0) && (iw_reg < $signed({2'b0, w_eff}));

    always_comb begin
        state_next    = state_reg;
        rstart_next   = rstart_reg;
        cstart_next   = cstart_reg;
        ih_next       = ih_reg;
        iw_next       = iw_reg;
        wci_next      = wci_reg;
        rowpart_next  = rowpart_reg;
        colpart_next  = colpart_reg;
        base_next     = base_reg;
        img_addr_next = img_addr_reg;
        row_addr_next = row_addr_reg;
        flt_addr_next = flt_addr_reg;
        co_next       = co_reg;
        ci_next       = ci_reg;
        kh_next       = kh_reg;
        kw_next       = kw_reg;
        drain_next    = drain_reg;
        acc_clr       = 1'b0;
        issue         = 1'b0;
        m_valid_next  = m_valid_reg && !m_tready;
        m_value_next  = m_value_reg;
        m_chan_next   = m_chan_reg;
        m_sat_next    = m_sat_reg;
        m_last_next   = m_last_reg;

        case (state_reg)
            ST_IDLE: begin
                if (start_px) begin
                    rstart_next = $signed(POS_W'(pixel_row)) - $signed(POS_W'(pad));
                    cstart_next = $signed(POS_W'(pixel_col)) - $signed(POS_W'(pad));
                    wci_next    = $signed(IA_W'(w_eff * ci_eff));
                    state_next  = ST_SETUP_A;
                end
            end
            ST_SETUP_A: begin
                rowpart_next = IA_W'(IA_W'(rstart_reg) * wci_reg);
                colpart_next = IA_W'(IA_W'(cstart_reg) * $signed(IA_W'(ci_eff)));
                state_next   = ST_SETUP_B;
            end
            ST_SETUP_B: begin
                base_next  = rowpart_reg + colpart_reg;
                state_next = ST_SETUP_C;
            end
            ST_SETUP_C: begin
                img_addr_next = base_reg;
                row_addr_next = base_reg;
                ih_next       = rstart_reg;
                iw_next       = cstart_reg;
                flt_addr_next = '0;
                co_next       = '0;
                ci_next       = '0;
                kh_next       = '0;
                kw_next       = '0;
                acc_clr       = 1'b1;
                state_next    = ST_RUN;
            end
            ST_RUN: begin
                issue         = 1'b1;
                flt_addr_next = flt_addr_reg + FLT_AW'(1);
                img_addr_next = img_addr_reg + IA_W'(1);
                ci_next       = ci_reg + CH_W'(1);
                if (ci_reg == ci_eff - CH_W'(1)) begin
                    ci_next = '0;
                    iw_next = iw_reg + POS_W'(1);
                    kw_next = kw_reg + KER_W'(1);
                    if (kw_reg == k_eff - KER_W'(1)) begin
                        // next kernel row
                        kw_next       = '0;
                        iw_next       = cstart_reg;
                        ih_next       = ih_reg + POS_W'(1);
                        kh_next       = kh_reg + KER_W'(1);
                        row_addr_next = row_addr_reg + wci_reg;
                        img_addr_next = row_addr_reg + wci_reg;
                        if (kh_reg == k_eff - KER_W'(1)) begin
                            drain_next = 2'd1;
                            state_next = ST_DRAIN;
                        end
                    end
                end
            end
            ST_DRAIN: begin
                drain_next = drain_reg - 2'd1;
                if (drain_reg == 2'd0) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_chan_next  = 3'(co_reg);
                    m_last_next  = (co_reg == co_eff - CH_W'(1));
                    if (acc_reg > SAT_HI) begin
                        m_value_next = 32'h7FFF_FFFF;
                        m_sat_next   = 1'b1;
                    end else if (acc_reg < SAT_LO) begin
                        m_value_next = 32'h8000_0000;
                        m_sat_next   = 1'b1;
                    end else begin
                        m_value_next = acc_reg[31:0];
                        m_sat_next   = 1'b0;
                    end
                    acc_clr = 1'b1;
                    if (co_reg == co_eff - CH_W'(1)) begin
                        state_next = ST_IDLE;
                    end else begin
                        // restart the window for the next filter
                        co_next       = co_reg + CH_W'(1);
                        img_addr_next = base_reg;
                        row_addr_next = base_reg;
                        ih_next       = rstart_reg;
                        iw_next       = cstart_reg;
                        ci_next       = '0;
                        kh_next       = '0;
                        kw_next       = '0;
                        state_next    = ST_RUN;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rstart_reg   <= rstart_next;
        cstart_reg   <= cstart_next;
        ih_reg       <= ih_next;
        iw_reg       <= iw_next;
        wci_reg      <= wci_next;
        rowpart_reg  <= rowpart_next;
        colpart_reg  <= colpart_next;
        base_reg     <= base_next;
        img_addr_reg <= img_addr_next;
        row_addr_reg <= row_addr_next;
        flt_addr_reg <= flt_addr_next;
        co_reg       <= co_next;
        ci_reg       <= ci_next;
        kh_reg       <= kh_next;
        kw_reg       <= kw_next;
        drain_reg    <= drain_next;
        m_value_reg  <= m_value_next;
        m_chan_reg   <= m_chan_next;
        m_sat_reg    <= m_sat_next;
        m_last_reg   <= m_last_next;
    end

    // stores
    logic [15:0] img_rdata, flt_rdata;

    mcconv_ram #(
        .DATA_W (16),
        .DEPTH  (IMG_DEPTH)
    ) u_img_ram (
        .aclk  (aclk),
        .we    (img_we),
        .waddr (IMG_AW'(load_index)),
        .wdata (load_value),
        .raddr (img_addr_reg[IMG_AW-1:0]),
        .rdata (img_rdata)
    );

    mcconv_ram #(
        .DATA_W (16),
        .DEPTH  (FLT_DEPTH)
    ) u_flt_ram (
        .aclk  (aclk),
        .we    (flt_we),
        .waddr (FLT_AW'(load_index)),
        .wdata (load_value),
        .raddr (flt_addr_reg),
        .rdata (flt_rdata)
    );

    // shared MAC: read, multiply, accumulate
    logic               p1_on_reg, p2_on_reg;
    logic signed [31:0] prod_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_on_reg <= 1'b0;
            p2_on_reg <= 1'b0;
        end else begin
            p1_on_reg <= issue && in_image;
            p2_on_reg <= p1_on_reg;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= $signed(img_rdata) * $signed(flt_rdata);
        if (acc_clr) begin
            acc_reg <= '0;
        end else if (p2_on_reg) begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_value_reg;
    assign m_tuser  = {m_sat_reg, m_chan_reg};
    assign m_tlast  = m_last_reg;

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps

module tb;
    import mcconv_pkg::*;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int IMG_DEPTH = 32 * 32 * 8;
    localparam int FLT_DEPTH = 8 * 5 * 5 * 8;
    localparam int STALL_LIMIT = 20000;
    localparam int HOLD_CYCLES = 3000;

    typedef struct packed {
        logic [1:0]  req;
        logic [12:0] idx;
        logic [15:0] val;
        logic [4:0]  row;
        logic [4:0]  col;
        logic        typed;
        logic [31:0] typed_sum;
        logic        typed_sat;
    } conv_req_t;

    typedef struct packed {
        logic [2:0]  ch;
        logic [31:0] sum;
        logic        sat;
        logic        last;
    } conv_res_t;

    typedef struct packed {
        logic [5:0] h;
        logic [5:0] w;
        logic [5:0] ci;
        logic [5:0] co;
        logic [5:0] k;
        int         items;
    } phase_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [S_TUSER_W-1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic m_tlast;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    multichannel_conv2d_same_pad_unit DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // predictor state
    logic signed [15:0] image_mem [IMG_DEPTH];
    logic signed [15:0] filter_mem [FLT_DEPTH];
    bit image_seeded [IMG_DEPTH];
    bit filter_seeded [FLT_DEPTH];
    logic [5:0] raw_h = 6'd32, raw_w = 6'd32;
    logic [3:0] raw_ci = 4'd8, raw_co = 4'd8;
    logic [2:0] raw_k = 3'd3;

    conv_req_t offered_q[$];
    conv_res_t pixel_results_q[$];
    int errors = 0;
    int n_loads = 0, n_pixels = 0, n_results = 0, n_sat = 0;
    int burst_left = 0;
    bit hold_req = 1'b0;

    function automatic int clamp_dim(int v, int hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic int eff_h();  return clamp_dim(raw_h, 32);  endfunction
    function automatic int eff_w();  return clamp_dim(raw_w, 32);  endfunction
    function automatic int eff_ci(); return clamp_dim(raw_ci, 8); endfunction
    function automatic int eff_co(); return clamp_dim(raw_co, 8); endfunction
    function automatic int eff_k();  return clamp_dim(raw_k, 5);  endfunction

    // sum one output pixel across all output channels and queue the results
    function automatic void predict_pixel(int row, int col);
        int hh, ww, ci, co, k, pad, ih, iw;
        longint acc;
        conv_res_t r;
        hh = eff_h(); ww = eff_w(); ci = eff_ci(); co = eff_co(); k = eff_k();
        pad = k / 2;
        for (int o = 0; o < co; o++) begin
            acc = 0;
            for (int c = 0; c < ci; c++)
                for (int kh = 0; kh < k; kh++)
                    for (int kw = 0; kw < k; kw++) begin
                        ih = row + kh - pad;
                        iw = col + kw - pad;
                        if (ih < 0 || iw < 0 || ih >= hh || iw >= ww) continue;
                        acc += longint'(image_mem[ih*ww*ci + iw*ci + c])
                             * longint'(filter_mem[o*k*k*ci + kh*k*ci + kw*ci + c]);
                    end
            r.ch = o[2:0];
            r.sat = 1'b0;
            if (acc > 64'sd2147483647) begin
                acc = 64'sd2147483647; r.sat = 1'b1;
            end
            if (acc < -64'sd2147483648) begin
                acc = -64'sd2147483648; r.sat = 1'b1;
            end
            r.sum = acc[31:0];
            r.last = (o + 1 == co);
            pixel_results_q.push_back(r);
        end
    endfunction

    task automatic report(string what);
        $display("[%0t] error: %s", $realtime, what);
        errors++;
    endtask

    // monitor: all handshakes sampled at the rising edge before the update
    int idle_cycles = 0;
    always @(posedge aclk) begin
        conv_req_t it;
        conv_res_t e;
        if (aresetn) begin
            idle_cycles++;
            if (s_tvalid && s_tready) begin
                idle_cycles = 0;
                if (offered_q.size() == 0) begin
                    report("input transfer with no item on offer");
                end else begin
                    it = offered_q.pop_front();
                    case (it.req)
                        REQ_LOAD_WEIGHT: begin
                            n_loads++;
                            if (it.idx < FLT_DEPTH) filter_mem[it.idx] = it.val;
                        end
                        REQ_LOAD_IMAGE: begin
                            n_loads++;
                            image_mem[it.idx] = it.val;
                        end
                        REQ_COMPUTE: begin
                            if (it.row < eff_h() && it.col < eff_w()) begin
                                n_pixels++;
                                if (it.typed) begin
                                    e.ch = '0; e.sum = it.typed_sum;
                                    e.sat = it.typed_sat; e.last = 1'b1;
                                    pixel_results_q.push_back(e);
                                end else begin
                                    predict_pixel(it.row, it.col);
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            if (m_tvalid && m_tready) begin
                idle_cycles = 0;
                n_results++;
                if (pixel_results_q.size() == 0) begin
                    report($sformatf("unexpected result ch %0d value %h",
                                     m_tuser[2:0], m_tdata));
                end else begin
                    e = pixel_results_q.pop_front();
                    if (m_tuser[2:0] !== e.ch)
                        report($sformatf("channel %0d, want %0d", m_tuser[2:0], e.ch));
                    if (m_tdata !== e.sum)
                        report($sformatf("ch %0d sum %h, want %h", e.ch, m_tdata, e.sum));
                    if (m_tuser[3] !== e.sat)
                        report($sformatf("ch %0d sat %b, want %b", e.ch, m_tuser[3], e.sat));
                    if (m_tlast !== e.last)
                        report($sformatf("ch %0d last %b, want %b", e.ch, m_tlast, e.last));
                    if (e.sat) n_sat++;
                end
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // receiver: random stalls, with an occasional long hold-off on request
    initial begin
        int mode;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end
            mode = int'(($time / 20000) % 3);
            case (mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 3) != 0);
                default: m_tready <= ($urandom_range(0, 1) != 0);
            endcase
        end
    end

    task automatic put_item(conv_req_t it);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 3) != 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser <= it.req;
        s_tdata <= {1'b0, it.col, it.row, it.val, it.idx};
        offered_q.push_back(it);
        do @(posedge aclk); while (!s_tready);
    endtask

    function automatic conv_req_t mk(logic [1:0] req, int idx, logic [15:0] val,
                                     int row, int col);
        conv_req_t it;
        it = '0;
        it.req = req; it.idx = idx[12:0]; it.val = val;
        it.row = row[4:0]; it.col = col[4:0];
        return it;
    endfunction

    function automatic logic [15:0] rand_q88();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($urandom_range(0, 255)) - 16'd128;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic load_entry(logic [1:0] req, int idx);
        if (req == REQ_LOAD_IMAGE) image_seeded[idx] = 1'b1;
        else if (idx < FLT_DEPTH) filter_seeded[idx] = 1'b1;
        put_item(mk(req, idx, rand_q88(), $urandom_range(0, 31), $urandom_range(0, 31)));
    endtask

    // write every entry a pixel will read that has never been loaded
    task automatic seed_pixel(int row, int col);
        int ww, ci, co, k, pad, ih, iw, ii, wi;
        ww = eff_w(); ci = eff_ci(); co = eff_co(); k = eff_k();
        pad = k / 2;
        for (int kh = 0; kh < k; kh++)
            for (int kw = 0; kw < k; kw++) begin
                ih = row + kh - pad;
                iw = col + kw - pad;
                if (ih < 0 || iw < 0 || ih >= eff_h() || iw >= ww) continue;
                for (int c = 0; c < ci; c++) begin
                    ii = ih*ww*ci + iw*ci + c;
                    if (!image_seeded[ii]) load_entry(REQ_LOAD_IMAGE, ii);
                    for (int o = 0; o < co; o++) begin
                        wi = o*k*k*ci + kh*k*ci + kw*ci + c;
                        if (!filter_seeded[wi]) load_entry(REQ_LOAD_WEIGHT, wi);
                    end
                end
            end
    endtask

    task automatic write_reg(logic [2:0] idx, logic [5:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_HEIGHT:       raw_h = value;
            REG_WIDTH:        raw_w = value;
            REG_IN_CHANNELS:  raw_ci = value[3:0];
            REG_OUT_CHANNELS: raw_co = value[3:0];
            REG_KERNEL_SIZE:  raw_k = value[2:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (offered_q.size() != 0 || pixel_results_q.size() != 0) @(posedge aclk);
        repeat (64) @(posedge aclk);
    endtask

    task automatic set_phase(phase_t p);
        write_reg(REG_HEIGHT, p.h);
        write_reg(REG_WIDTH, p.w);
        write_reg(REG_IN_CHANNELS, p.ci);
        write_reg(REG_OUT_CHANNELS, p.co);
        write_reg(REG_KERNEL_SIZE, p.k);
    endtask

    conv_req_t directed_tbl[$];
    phase_t phases[$];

    initial begin
        conv_req_t it;
        int row, col, sel;
        for (int i = 0; i < 4; i++) directed_tbl.push_back(mk(REQ_LOAD_IMAGE, i, 16'h8000, 0, 0));
        for (int i = 0; i < 4; i++) directed_tbl.push_back(mk(REQ_LOAD_WEIGHT, i, 16'h8000, 0, 0));
        // four largest positive products overflow the top of range
        it = mk(REQ_COMPUTE, 0, 16'h0, 0, 0);
        it.typed = 1'b1; it.typed_sum = 32'h7FFFFFFF; it.typed_sat = 1'b1;
        directed_tbl.push_back(it);
        for (int i = 0; i < 4; i++) directed_tbl.push_back(mk(REQ_LOAD_WEIGHT, i, 16'h7FFF, 0, 0));
        it.typed_sum = 32'h80000000;
        directed_tbl.push_back(it);
        for (int i = 1; i < 4; i++) directed_tbl.push_back(mk(REQ_LOAD_WEIGHT, i, 16'h0, 0, 0));
        it.typed_sum = 32'hC0008000; it.typed_sat = 1'b0;
        directed_tbl.push_back(it);
        directed_tbl.push_back(mk(REQ_UNUSED, 5, 16'h5555, 0, 0));
        directed_tbl.push_back(mk(REQ_LOAD_WEIGHT, 8191, 16'h1234, 0, 0));
        directed_tbl.push_back(mk(REQ_COMPUTE, 0, 16'h0, 1, 0));
        directed_tbl.push_back(mk(REQ_COMPUTE, 0, 16'h0, 0, 2));
        directed_tbl.push_back(mk(REQ_COMPUTE, 0, 16'h0, 31, 31));
        directed_tbl.push_back(mk(REQ_LOAD_IMAGE, 8191, 16'hFFFF, 0, 0));
        directed_tbl.push_back(mk(REQ_COMPUTE, 0, 16'h0, 0, 0));

        phases = '{
            '{6'd1, 6'd2, 6'd4, 6'd1, 6'd1, 0},
            '{6'd63, 6'd63, 6'd1, 6'd1, 6'd3, 8},
            '{6'd3, 6'd4, 6'd2, 6'd2, 6'd2, 25},
            '{6'd0, 6'd0, 6'd15, 6'd15, 6'd7, 4},
            '{6'd4, 6'd3, 6'd1, 6'd2, 6'd4, 15},
            '{6'd3, 6'd3, 6'd2, 6'd1, 6'd0, 20},
            '{6'd32, 6'd1, 6'd0, 6'd1, 6'd5, 12},
            '{6'd4, 6'd32, 6'd2, 6'd2, 6'd1, 15}
        };

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        set_phase(phases[0]);
        foreach (directed_tbl[i]) begin
            if (directed_tbl[i].req == REQ_LOAD_IMAGE) image_seeded[directed_tbl[i].idx] = 1'b1;
            if (directed_tbl[i].req == REQ_LOAD_WEIGHT && directed_tbl[i].idx < FLT_DEPTH)
                filter_seeded[directed_tbl[i].idx] = 1'b1;
            put_item(directed_tbl[i]);
        end
        drain();

        for (int p = 1; p < phases.size(); p++) begin
            set_phase(phases[p]);
            // the block fills and stalls its input while the receiver holds off
            if (p == 2) hold_req = 1'b1;
            for (int n = 0; n < phases[p].items; n++) begin
                sel = $urandom_range(0, 9);
                if (sel < 6) begin
                    if ($urandom_range(0, 5) == 0) begin
                        row = $urandom_range(0, 31);
                        col = $urandom_range(0, 31);
                    end else begin
                        row = $urandom_range(0, eff_h() - 1);
                        col = $urandom_range(0, eff_w() - 1);
                    end
                    if (row < eff_h() && col < eff_w()) seed_pixel(row, col);
                    put_item(mk(REQ_COMPUTE, $urandom_range(0, 8191), 16'($urandom), row, col));
                end else if (sel < 8) begin
                    load_entry(REQ_LOAD_IMAGE, $urandom_range(0, IMG_DEPTH - 1));
                end else if (sel < 9) begin
                    load_entry(REQ_LOAD_WEIGHT, $urandom_range(0, 2047));
                end else begin
                    put_item(mk(REQ_UNUSED, $urandom_range(0, 8191), 16'($urandom),
                                $urandom_range(0, 31), $urandom_range(0, 31)));
                end
            end
            drain();
        end

        $display("covered %0d loads, %0d pixels, %0d channel results (%0d clipped)",
                 n_loads, n_pixels, n_results, n_sat);
        $display("over %0d size settings including clamped register values", phases.size());
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

>>> sim.f
hdl/mcconv_pkg.sv
hdl/mcconv_ram.sv
hdl/multichannel_conv2d_same_pad_unit.sv
dv/tb.sv
